// ===== design/cprsw_pkg.sv =====
// ----------------------------------------------------------------------------
// cprsw_pkg
// Shared types and constants for the convex polygon row span walker.
// ----------------------------------------------------------------------------
package cprsw_pkg;

    localparam int CFG_W   = 13;
    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;

    localparam logic [CFG_W-1:0] REG_TILE_COLUMNS = 13'd0;
    localparam logic [CFG_W-1:0] REG_TILE_ROWS    = 13'd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // write vertex, handle last marker
        logic begin_step; // latch row, set up chain walk
        logic left_side;  // current chain: 1 left, 0 right
        logic walk;       // examine neighbor on current chain
        logic div_start;  // start interpolation divide
        logic div_run;    // one divider iteration
        logic edge_fin;   // finish interpolation, update edge x
        logic finish;     // build result
    } cprsw_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic empty;      // no polygon
        logic chain_end;  // chain turned upward or edge crosses row
        logic need_div;   // crossing edge needs a divide
        logic div_done;
    } cprsw_sts_t;

endpackage

// ===== design/cprsw_ctrl.sv =====
// ----------------------------------------------------------------------------
// cprsw_ctrl
// Sequencer: accepts requests, walks both chains, runs divides, holds result.
// ----------------------------------------------------------------------------
module cprsw_ctrl #(
    parameter int MAX_CORNERS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_opcode,
    output logic                   m_valid,
    input  logic                   m_ready,
    output cprsw_pkg::cprsw_cmd_t  cmd,
    input  cprsw_pkg::cprsw_sts_t  sts
);
    import cprsw_pkg::*;

    localparam int CW = $clog2(MAX_CORNERS + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_WALK  = 7'b0000010,
        ST_DIVS  = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_EDGE  = 7'b0010000,
        ST_FIN   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t        state_reg, state_next;
    logic          left_reg, left_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic acc;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign acc     = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        left_next  = left_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.left_side = left_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    if (s_opcode == OP_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.begin_step = 1'b1;
                        left_next  = 1'b1;
                        cnt_next   = '0;
                        state_next = sts.empty ? ST_FIN : ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (sts.chain_end || cnt_reg == CW'(MAX_CORNERS - 1)) begin
                    if (sts.chain_end && sts.need_div) begin
                        state_next = ST_DIVS;
                    end else if (left_reg) begin
                        left_next = 1'b0;
                        cnt_next  = '0;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_DIVS: begin
                cmd.div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_run = 1'b1;
                if (sts.div_done) state_next = ST_EDGE;
            end
            ST_EDGE: begin
                cmd.edge_fin = 1'b1;
                if (left_reg) begin
                    left_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_WALK;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            left_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            left_reg  <= left_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== design/cprsw_dp.sv =====
// ----------------------------------------------------------------------------
// cprsw_dp
// Datapath: vertex stores, chain pointers, edge interpolation, span build.
// ----------------------------------------------------------------------------
module cprsw_dp #(
    parameter int MAX_CORNERS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cprsw_pkg::cprsw_cmd_t cmd,
    output cprsw_pkg::cprsw_sts_t sts,
    input  logic                  cfg_we,
    input  logic [12:0]           cfg_index,
    input  logic [12:0]           cfg_data,
    input  logic signed [31:0]    s_vertex_x,
    input  logic signed [31:0]    s_vertex_y,
    input  logic                  s_last_vertex,
    output logic [14:0]           m_span_start,
    output logic signed [15:0]    m_span_end,
    output logic [11:0]           m_row,
    output logic                  m_more_rows
);
    import cprsw_pkg::*;

    localparam int IW = $clog2(MAX_CORNERS);
    localparam int CW = $clog2(MAX_CORNERS + 1);

    logic signed [31:0] xs_reg [MAX_CORNERS];
    logic signed [31:0] ys_reg [MAX_CORNERS];
    logic [CW-1:0] count_reg, lptr_reg;
    logic [IW-1:0] lc_reg, rc_reg;
    logic signed [31:0] cury_reg, lex_reg, rex_reg;
    logic [CFG_W-1:0] cols_reg, rows_reg;

    logic signed [32:0] ny_reg;      // next row y, before saturation
    logic signed [32:0] lo_reg, hi_reg;
    logic               more_reg;
    logic signed [16:0] yint_reg;

    // divider state: t = num*2^16/den, restoring, 16 quotient bits
    logic [32:0] rem_reg, den_reg;
    logic [16:0] q_reg;
    logic [4:0]  dcnt_reg;
    logic [IW-1:0] ea_reg;
    logic        tclamp_reg, tzero_reg;
    logic signed [33:0] dx_reg;

    logic [14:0] ss_reg;
    logic signed [15:0] se_reg;
    logic [11:0] row_reg;
    logic        hm_reg;

    logic [IW-1:0] slot, cur, p;
    logic [CW-1:0] nn;
    assign nn   = count_reg;
    assign slot = (lptr_reg >= CW'(MAX_CORNERS)) ? IW'(MAX_CORNERS - 1) : lptr_reg[IW-1:0];
    assign cur  = cmd.left_side ? lc_reg : rc_reg;

    always_comb begin
        if (cmd.left_side)
            p = (lc_reg == '0) ? IW'(nn - 1'b1) : lc_reg - 1'b1;
        else
            p = ({1'b0, rc_reg} + 1'b1 >= {1'b0, nn}) ? '0 : rc_reg + 1'b1;
    end

    logic signed [31:0] yp, yc, xp, xc;
    assign yp = ys_reg[p];
    assign yc = ys_reg[cur];
    assign xp = xs_reg[p];
    assign xc = xs_reg[cur];
    logic upturn, passed;
    assign upturn = yp < yc;
    assign passed = 33'(yp) < ny_reg;
    assign sts.empty     = (count_reg == '0);
    assign sts.chain_end = upturn || !passed;
    assign sts.need_div  = !upturn;
    assign sts.div_done  = (dcnt_reg == 5'd0);

    // divide setup from edge cur -> p
    logic signed [33:0] den_s, num_s, den_a, num_a;
    assign den_s = 34'(yp) - 34'(yc);
    assign num_s = 34'(ny_reg) - 34'(yc);
    assign den_a = den_s[33] ? -den_s : den_s;
    assign num_a = den_s[33] ? -num_s : num_s;

    // step setup
    logic signed [32:0] cfloor, nys;
    always_comb begin
        cfloor = 33'(cury_reg) >>> FRAC_W;
        nys    = (cfloor + 33'sd1) <<< FRAC_W;
    end
    logic signed [32:0] nyi;
    always_comb begin
        // ceil(cy)*1.0, plus 1.0 if already whole == floor(cy)+1
        nyi = nys;
    end

    // divide step
    logic [33:0] trial;
    assign trial = {rem_reg, 1'b0} - {1'b0, den_reg};

    // edge result: x0 + floor(dx*t)
    logic signed [51:0] prod;
    logic signed [31:0] ex;
    logic [16:0] tq;
    assign tq   = tzero_reg ? 17'd0 : (tclamp_reg ? 17'h10000 : q_reg);
    assign prod = 52'(dx_reg) * $signed({1'b0, tq});
    assign ex   = 32'(34'(xs_reg[ea_reg]) + 34'(prod >>> FRAC_W));

    // finish
    logic signed [32:0] sfl, ecl;
    logic signed [16:0] yint_w;
    assign sfl    = lo_reg >>> FRAC_W;
    assign ecl    = -((-hi_reg) >>> FRAC_W);
    logic in_grid;
    assign in_grid = !yint_reg[16] && (yint_reg[15:0] < 16'(rows_reg));
    assign yint_w  = 17'(cfloor);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0; lptr_reg <= '0; lc_reg <= '0; rc_reg <= '0;
            cury_reg <= '0; lex_reg <= '0; rex_reg <= '0;
            cols_reg <= 13'd64; rows_reg <= 13'd64;
            dcnt_reg <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_TILE_COLUMNS) cols_reg <= cfg_data;
                else if (cfg_index == REG_TILE_ROWS) rows_reg <= cfg_data;
            end
            if (cmd.load) begin
                xs_reg[slot] <= s_vertex_x;
                ys_reg[slot] <= s_vertex_y;
                if (s_last_vertex) begin
                    count_reg <= (lptr_reg < CW'(MAX_CORNERS)) ? lptr_reg + 1'b1 : lptr_reg;
                    lptr_reg <= '0; lc_reg <= '0; rc_reg <= '0;
                    cury_reg <= (slot == '0) ? s_vertex_y : ys_reg[0];
                    lex_reg  <= (slot == '0) ? s_vertex_x : xs_reg[0];
                    rex_reg  <= (slot == '0) ? s_vertex_x : xs_reg[0];
                end else if (lptr_reg < CW'(MAX_CORNERS)) begin
                    lptr_reg <= lptr_reg + 1'b1;
                end
            end
            if (cmd.begin_step && count_reg != '0) begin
                if ({1'b0, lc_reg} >= count_reg) lc_reg <= '0;
                if ({1'b0, rc_reg} >= count_reg) rc_reg <= '0;
                ny_reg   <= nyi;
                lo_reg   <= 33'(lex_reg);
                hi_reg   <= 33'(rex_reg);
                more_reg <= 1'b1;
                yint_reg <= yint_w;
            end
            if (cmd.walk) begin
                if (upturn) begin
                    more_reg <= 1'b0;
                end else if (passed) begin
                    if (cmd.left_side) begin
                        if (33'(xp) < lo_reg) lo_reg <= 33'(xp);
                        lc_reg <= p;
                    end else begin
                        if (33'(xp) > hi_reg) hi_reg <= 33'(xp);
                        rc_reg <= p;
                    end
                end else begin
                    ea_reg     <= cur;
                    den_reg    <= den_a[32:0];
                    rem_reg    <= num_a[32:0];
                    tzero_reg  <= (den_s == '0) || (num_a <= 0);
                    tclamp_reg <= (num_a >= den_a);
                    dx_reg     <= 34'(xp) - 34'(xc);
                end
            end
            if (cmd.div_start) begin
                q_reg    <= '0;
                dcnt_reg <= 5'd16;
                // remainder starts as num; shift in quotient bits of num/den.
                // num < den here, so integer quotient bit is zero.
                rem_reg  <= rem_reg;
            end
            if (cmd.div_run && dcnt_reg != 5'd0) begin
                dcnt_reg <= dcnt_reg - 1'b1;
                if (!trial[33]) begin
                    rem_reg <= trial[32:0];
                    q_reg   <= {q_reg[15:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[31:0], 1'b0};
                    q_reg   <= {q_reg[15:0], 1'b0};
                end
            end
            if (cmd.edge_fin) begin
                if (cmd.left_side) begin
                    lex_reg <= ex;
                    if (33'(ex) < lo_reg) lo_reg <= 33'(ex);
                end else begin
                    rex_reg <= ex;
                    if (33'(ex) > hi_reg) hi_reg <= 33'(ex);
                end
            end
            if (cmd.finish && count_reg != '0) begin
                cury_reg <= (ny_reg > 33'sh7FFFFFFF) ? 32'sh7FFFFFFF : ny_reg[31:0];
            end
        end
    end

    // first divide iteration compares num*2 against den; 16 iterations give
    // floor(num*2^16/den), the integer bit being zero since num < den
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            if (count_reg == '0) begin
                ss_reg <= '0; se_reg <= '0; row_reg <= '0; hm_reg <= 1'b0;
            end else if (!in_grid) begin
                ss_reg <= '0; se_reg <= '0; row_reg <= '0;
                hm_reg <= more_reg && (yint_reg[16] || yint_reg[15:0] < 16'(rows_reg));
            end else begin
                ss_reg  <= sfl[32] ? 15'd0 : sfl[14:0];
                se_reg  <= (ecl > $signed({20'd0, cols_reg})) ? 16'(cols_reg) : ecl[15:0];
                row_reg <= yint_reg[11:0];
                hm_reg  <= more_reg;
            end
        end
    end

    assign m_span_start = ss_reg;
    assign m_span_end   = se_reg;
    assign m_row        = row_reg;
    assign m_more_rows  = hm_reg;

endmodule

// ===== design/convex_polygon_row_span_walker_unit.sv =====
// ----------------------------------------------------------------------------
// convex_polygon_row_span_walker_unit
// Walks a loaded convex polygon row by row and returns clamped tile spans.
// ----------------------------------------------------------------------------
// A step request walks the left chain, then the
// right chain, one vertex per cycle, and runs a shared restoring divider for
// each chain that ends on a crossing edge. The result is held in an output
// register until taken; the next request is taken after that.
module convex_polygon_row_span_walker_unit #(
    parameter int MAX_CORNERS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [12:0]        cfg_index,
    input  logic [12:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic signed [31:0] s_vertex_x,
    input  logic signed [31:0] s_vertex_y,
    input  logic               s_last_vertex,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [14:0]        m_span_start,
    output logic signed [15:0] m_span_end,
    output logic [11:0]        m_row,
    output logic               m_more_rows
);
    import cprsw_pkg::*;

    cprsw_cmd_t cmd;
    cprsw_sts_t sts;

    cprsw_ctrl #(.MAX_CORNERS(MAX_CORNERS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_opcode(s_opcode), .m_valid(m_valid), .m_ready(m_ready),
        .cmd(cmd), .sts(sts)
    );

    cprsw_dp #(.MAX_CORNERS(MAX_CORNERS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_vertex_x(s_vertex_x), .s_vertex_y(s_vertex_y),
        .s_last_vertex(s_last_vertex),
        .m_span_start(m_span_start), .m_span_end(m_span_end),
        .m_row(m_row), .m_more_rows(m_more_rows)
    );

endmodule

// ===== bench/convex_polygon_row_span_walker_unit_tb.sv =====
// ----------------------------------------------------------------------------
// convex_polygon_row_span_walker_unit_tb
// Loads convex polygons of random shape and position, along with noise loads
// and broken vertex lists, then steps them row by row. Random idling is applied
// on both the request and result sides. A local row walk model predicts each
// span, and every returned span is checked field by field against it.
// ----------------------------------------------------------------------------
module convex_polygon_row_span_walker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cprsw_pkg::*;

    localparam int  CORNERS   = 8;
    localparam longint ONE    = 65536;
    localparam int  SETTLE    = 80;
    localparam int  STALL_MAX = 20000;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               last;
    } request_t;

    typedef struct packed {
        logic [14:0]        span_start;
        logic signed [15:0] span_end;
        logic [11:0]        row;
        logic               more_rows;
    } span_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [12:0]        cfg_index = '0;
    logic [12:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_opcode = 1'b0;
    logic signed [31:0] s_vertex_x = '0;
    logic signed [31:0] s_vertex_y = '0;
    logic               s_last_vertex = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [14:0]        m_span_start;
    logic signed [15:0] m_span_end;
    logic [11:0]        m_row;
    logic               m_more_rows;

    convex_polygon_row_span_walker_unit #(.MAX_CORNERS(CORNERS)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_vertex_x(s_vertex_x), .s_vertex_y(s_vertex_y), .s_last_vertex(s_last_vertex),
        .m_valid(m_valid), .m_ready(m_ready), .m_span_start(m_span_start),
        .m_span_end(m_span_end), .m_row(m_row), .m_more_rows(m_more_rows)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    request_t pending_q[$];
    span_t    span_q[$];
    int       fail_count = 0;
    bit       steady_mode = 0;

    // row walk model state
    longint   px[CORNERS];
    longint   py[CORNERS];
    int       n_corners, load_ptr, l_idx, r_idx;
    longint   row_y, l_edge, r_edge;
    longint   cols = 64, rows = 64;

    function automatic longint fl16(longint a);
        if (a >= 0) return a / ONE;
        return -((-a + ONE - 1) / ONE);
    endfunction

    function automatic longint cl16(longint a);
        return -fl16(-a);
    endfunction

    function automatic longint cross_x(int a, int b, longint ry);
        longint den, num, t, v;
        den = py[b] - py[a];
        num = ry - py[a];
        if (den == 0) return px[a];
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        if (num <= 0) t = 0;
        else if (num >= den) t = ONE;
        else t = (num * ONE) / den;
        v = px[a] + fl16((px[b] - px[a]) * t);
        return longint'(int'(v));
    endfunction

    function automatic bit predict(input request_t q, output span_t r);
        longint ny, lo, hi, yi, s, e;
        bit more;
        int slot, p;
        more = 1;
        r = '0;
        if (q.opcode == OP_LOAD) begin
            slot = load_ptr < CORNERS ? load_ptr : CORNERS - 1;
            px[slot] = q.vx;
            py[slot] = q.vy;
            if (load_ptr < CORNERS) load_ptr++;
            if (q.last) begin
                n_corners = load_ptr;
                load_ptr = 0;
                l_idx = 0;
                r_idx = 0;
                row_y = py[0];
                l_edge = px[0];
                r_edge = px[0];
            end
            return 0;
        end
        if (n_corners == 0) return 1;
        if (l_idx >= n_corners) l_idx = 0;
        if (r_idx >= n_corners) r_idx = 0;
        ny = cl16(row_y) * ONE;
        if (ny == row_y) ny += ONE;
        lo = l_edge;
        hi = r_edge;
        for (int i = 0; i < n_corners; i++) begin
            p = l_idx == 0 ? n_corners - 1 : l_idx - 1;
            if (py[p] < py[l_idx]) begin
                more = 0;
                break;
            end
            if (py[p] < ny) begin
                if (px[p] < lo) lo = px[p];
                l_idx = p;
            end else begin
                l_edge = cross_x(l_idx, p, ny);
                if (l_edge < lo) lo = l_edge;
                break;
            end
        end
        for (int i = 0; i < n_corners; i++) begin
            p = r_idx + 1 >= n_corners ? 0 : r_idx + 1;
            if (py[p] < py[r_idx]) begin
                more = 0;
                break;
            end
            if (py[p] < ny) begin
                if (px[p] > hi) hi = px[p];
                r_idx = p;
            end else begin
                r_edge = cross_x(r_idx, p, ny);
                if (r_edge > hi) hi = r_edge;
                break;
            end
        end
        yi = fl16(row_y);
        row_y = ny > 64'sd2147483647 ? 64'sd2147483647 : ny;
        if (yi < 0 || yi >= rows) begin
            r.more_rows = more && yi < rows;
            return 1;
        end
        s = fl16(lo);
        if (s < 0) s = 0;
        e = cl16(hi);
        if (e > cols) e = cols;
        r.span_start = s[14:0];
        r.span_end   = e[15:0];
        r.row        = yi[11:0];
        r.more_rows  = more;
        return 1;
    endfunction

    function automatic int pick_gap();
        int k;
        if (steady_mode) return 0;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // request driver
    int  send_gap = 0;
    always @(posedge aclk) begin
        span_t exp_span;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid && predict({s_opcode, s_vertex_x, s_vertex_y, s_last_vertex},
                                   exp_span))
                span_q.push_back(exp_span);
            if (send_gap == 0 && pending_q.size() > 0) begin
                request_t q;
                q = pending_q.pop_front();
                s_opcode      <= q.opcode;
                s_vertex_x    <= q.vx;
                s_vertex_y    <= q.vy;
                s_last_vertex <= q.last;
                s_valid       <= 1'b1;
                send_gap      = pick_gap();
            end else begin
                s_valid <= 1'b0;
                if (send_gap > 0) send_gap--;
            end
        end
    end

    // result monitor and receiver stalls
    int recv_gap = 0;
    always @(posedge aclk) begin
        span_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_span_start, m_span_end, m_row, m_more_rows};
            if (span_q.size() == 0) begin
                $display("%t: span with no request waiting, actual %h", $realtime, got);
                fail_count++;
            end else begin
                want = span_q.pop_front();
                if (got.span_start !== want.span_start) begin
                    $display("%t: span_start expected %0d actual %0d", $realtime,
                             want.span_start, got.span_start);
                    fail_count++;
                end
                if (got.span_end !== want.span_end) begin
                    $display("%t: span_end expected %0d actual %0d", $realtime,
                             want.span_end, got.span_end);
                    fail_count++;
                end
                if (got.row !== want.row) begin
                    $display("%t: row expected %0d actual %0d", $realtime,
                             want.row, got.row);
                    fail_count++;
                end
                if (got.more_rows !== want.more_rows) begin
                    $display("%t: more_rows expected %0d actual %0d", $realtime,
                             want.more_rows, got.more_rows);
                    fail_count++;
                end
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready  <= 1'b1;
            recv_gap = (m_valid && m_ready) ? pick_gap() : 0;
        end
    end

    // watchdog on accepted traffic
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("convex_polygon_row_span_walker_unit regression: fail");
            $finish;
        end
    end

    task automatic push_req(logic op, longint x, longint y, logic lv);
        request_t q;
        q.opcode = op;
        q.vx = x[31:0];
        q.vy = y[31:0];
        q.last = lv;
        pending_q.push_back(q);
    endtask

    task automatic push_steps(int k);
        for (int i = 0; i < k; i++)
            push_req(OP_STEP, $urandom, $urandom, 1'($urandom_range(0, 1)));
    endtask

    // convex polygon on a circle, vertex 0 rotated to the top
    task automatic push_polygon(int nv, real cx, real cy, real rad, bit finish);
        real ang[CORNERS];
        real t;
        longint qx[CORNERS], qy[CORNERS];
        int top;
        for (int i = 0; i < nv; i++) ang[i] = $urandom_range(0, 35999) / 100.0;
        for (int i = 0; i < nv; i++)
            for (int j = i + 1; j < nv; j++)
                if (ang[j] < ang[i]) begin
                    t = ang[i];
                    ang[i] = ang[j];
                    ang[j] = t;
                end
        top = 0;
        for (int i = 0; i < nv; i++) begin
            qx[i] = longint'($rtoi((cx + rad * $cos(ang[i] * 3.14159265 / 180.0)) * 65536.0));
            qy[i] = longint'($rtoi((cy + rad * $sin(ang[i] * 3.14159265 / 180.0)) * 65536.0));
            if (qy[i] < qy[top]) top = i;
        end
        for (int i = 0; i < nv; i++)
            push_req(OP_LOAD, qx[(top + i) % nv], qy[(top + i) % nv],
                     finish && i == nv - 1);
        if (finish) push_steps($rtoi(2.0 * rad) + $urandom_range(1, 3));
    endtask

    task automatic write_reg(logic [12:0] idx, logic [12:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_TILE_COLUMNS) cols = val;
        else rows = val;
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || s_valid || span_q.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic random_phase(int budget);
        int k;
        int m;
        real rad;
        while (pending_q.size() < budget) begin
            k = $urandom_range(0, 99);
            rad = ($urandom_range(0, 99) < 90) ? $urandom_range(30, 600) / 100.0
                                               : $urandom_range(600, 2000) / 100.0;
            if (k < 75) begin
                push_polygon($urandom_range(3, CORNERS),
                             $urandom_range(0, (cols > 200 ? 200 : cols) + 8) - 4.0
                                 + $urandom_range(0, 99) / 100.0,
                             $urandom_range(0, (rows > 200 ? 200 : rows) + 8) - 4.0
                                 + $urandom_range(0, 99) / 100.0,
                             rad, 1);
            end else if (k < 85) begin
                // unterminated list, next polygon continues the load pointer
                push_polygon($urandom_range(1, 4), 10.0, 10.0, 3.0, 0);
            end else if (k < 93) begin
                m = $urandom_range(3, 10);
                for (int i = 0; i < m; i++)
                    push_req(OP_LOAD, $urandom, $urandom, i == m - 1);
                push_steps($urandom_range(1, 4));
            end else begin
                push_steps($urandom_range(1, 3));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty walk, extremes, flat edges, overflow, too many vertices
        push_steps(1);
        push_req(OP_LOAD, 0, 0, 0);
        push_req(OP_LOAD, 5 * ONE, 2 * ONE, 0);
        push_req(OP_LOAD, 5 * ONE, 2 * ONE, 0);
        push_req(OP_LOAD, 0, 2 * ONE, 1);
        push_steps(4);
        push_req(OP_LOAD, -64'sd2147483648, -64'sd2147483648, 0);
        push_req(OP_LOAD, 64'sd2147483647, 64'sd2147483647, 0);
        push_req(OP_LOAD, -64'sd2147483648, 64'sd2147483647, 1);
        push_steps(2);
        push_req(OP_LOAD, ONE, 64'sd2147450880, 0);
        push_req(OP_LOAD, 3 * ONE, 64'sd2147483647, 0);
        push_req(OP_LOAD, 0, 64'sd2147483647, 1);
        push_steps(3);
        for (int i = 0; i < 10; i++) push_req(OP_LOAD, i * ONE, (i % 3) * ONE, i == 9);
        push_steps(2);
        drain();

        write_reg(REG_TILE_COLUMNS, 13'd64);
        write_reg(REG_TILE_ROWS, 13'd64);
        random_phase(150);
        drain();
        write_reg(REG_TILE_COLUMNS, 13'd1);
        write_reg(REG_TILE_ROWS, 13'd1);
        random_phase(100);
        drain();
        steady_mode = 1;
        write_reg(REG_TILE_COLUMNS, 13'd4096);
        write_reg(REG_TILE_ROWS, 13'd4096);
        random_phase(150);
        drain();
        steady_mode = 0;
        for (int ph = 0; ph < 3; ph++) begin
            write_reg(REG_TILE_COLUMNS, 13'($urandom_range(1, 4096)));
            write_reg(REG_TILE_ROWS, 13'($urandom_range(1, 40)));
            random_phase(130);
            drain();
        end

        if (fail_count == 0)
            $display("convex_polygon_row_span_walker_unit regression: pass");
        else
            $display("convex_polygon_row_span_walker_unit regression: fail");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/cprsw_pkg.sv
design/cprsw_ctrl.sv
design/cprsw_dp.sv
design/convex_polygon_row_span_walker_unit.sv
bench/convex_polygon_row_span_walker_unit_tb.sv
